>>> hdl/dqs_pkg.sv
// shared constants, status codes and tables for the diffraction angle to q core
package dqs_pkg;

  localparam int IDX_W    = 10;
  localparam int ANGLE_W  = 25;
  localparam int ZS_W     = 19;
  localparam int WL_W     = 20;
  localparam int Q_W      = 40;
  localparam int VAR_W    = 56;
  localparam int ST_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 24;
  localparam int INDEX_BITS_DEF      = 10;

  localparam int XY_W = 33;
  localparam int Z_W  = 36;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_NEG_WIDTH  = 2'd1;
  localparam logic [ST_W-1:0] ST_SINE_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_WAVE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH = 1'd1;

  localparam logic [WL_W-1:0] WAVELENGTH_RESET = 20'd100965;

  localparam logic [34:0] DEG_TO_RAD_Q40 = 35'd19190098068;
  localparam logic [34:0] ERR_TO_RAD_Q40 = 35'd8149284320;
  localparam logic [33:0] PI_Q31         = 34'd6746518852;
  localparam logic [33:0] HALF_PI_Q31    = 34'd3373259426;
  localparam logic [33:0] TWO_PI_Q31     = 34'd13493037704;
  localparam logic [30:0] GAIN_Q30       = 31'd652032874;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

>>> hdl/dqs_cordic_cell.sv
// one rotation-mode cordic iteration with registered outputs
module dqs_cordic_cell #(
  parameter int STAGE = 0,
  parameter int SB_W  = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  dqs_pkg::stage_ctl_t               in_ctl,
  input  logic signed [dqs_pkg::XY_W-1:0]   in_x,
  input  logic signed [dqs_pkg::XY_W-1:0]   in_y,
  input  logic signed [dqs_pkg::Z_W-1:0]    in_z,
  input  logic [SB_W-1:0]                   in_sb,
  output dqs_pkg::stage_ctl_t               out_ctl,
  output logic signed [dqs_pkg::XY_W-1:0]   out_x,
  output logic signed [dqs_pkg::XY_W-1:0]   out_y,
  output logic signed [dqs_pkg::Z_W-1:0]    out_z,
  output logic [SB_W-1:0]                   out_sb
);

  localparam logic signed [dqs_pkg::Z_W-1:0] STEP =
    $signed(dqs_pkg::Z_W'({dqs_pkg::ATAN_Q30[STAGE], 1'b0}));

  logic                             valid_r;
  logic signed [dqs_pkg::XY_W-1:0]  x_r, x_nxt;
  logic signed [dqs_pkg::XY_W-1:0]  y_r, y_nxt;
  logic signed [dqs_pkg::Z_W-1:0]   z_r, z_nxt;
  logic [SB_W-1:0]                  sb_r;
  logic signed [dqs_pkg::XY_W-1:0]  dx, dy;

  always_comb begin
    dx = in_y >>> STAGE;
    dy = in_x >>> STAGE;
    if (!in_z[dqs_pkg::Z_W-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - STEP;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_ctl.valid = valid_r;
  assign out_x  = x_r;
  assign out_y  = y_r;
  assign out_z  = z_r;
  assign out_sb = sb_r;

endmodule

>>> hdl/dqs_div_cell.sv
// one restoring division step, dividend shifts out as quotient shifts in
module dqs_div_cell #(
  parameter int DIV_W = 20,
  parameter int ACC_W = 59,
  parameter int SB_W  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic [DIV_W-1:0]    divisor,
  input  dqs_pkg::stage_ctl_t in_ctl,
  input  logic [DIV_W-1:0]    in_rem,
  input  logic [ACC_W-1:0]    in_acc,
  input  logic [SB_W-1:0]     in_sb,
  output dqs_pkg::stage_ctl_t out_ctl,
  output logic [DIV_W-1:0]    out_rem,
  output logic [ACC_W-1:0]    out_acc,
  output logic [SB_W-1:0]     out_sb
);

  logic              valid_r;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SB_W-1:0]   sb_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  always_comb begin
    trial   = {in_rem, in_acc[ACC_W-1]};
    diff    = trial - {1'b0, divisor};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    acc_nxt = {in_acc[ACC_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      sb_r  <= in_sb;
    end
  end

  assign out_ctl.valid = valid_r;
  assign out_rem = rem_r;
  assign out_acc = acc_r;
  assign out_sb  = sb_r;

endmodule

>>> hdl/diffraction_angle_to_q_core.sv
// top level: peak 2-theta and width to q and its variance, fully pipelined
// throughput: one peak per cycle while the output skid register is empty; set by the cordic and divider cell chains
// skipped peaks (use flag clear) produce no transfer on the output
// reset: synchronous active low, clears all valid bits, zero_shift to 0, wavelength to 100965
module diffraction_angle_to_q_core #(
  parameter int ANGLE_FRAC_BITS = dqs_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = dqs_pkg::CORDIC_STAGES_DEF,
  parameter int INDEX_BITS      = dqs_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // peak_index, position_deg, width_deg
  input  logic [63:0]                      in_tdata,
  // use_peak
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // result_index, q_value, q_variance
  output logic [111:0]                     out_tdata,
  // status
  output logic [dqs_pkg::ST_W-1:0]         out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dqs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dqs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IW     = dqs_pkg::IDX_W;
  localparam int SW_ST  = dqs_pkg::ST_W;
  localparam int SH     = ANGLE_FRAC_BITS + 10;
  localparam int RAD_W  = 51 - ANGLE_FRAC_BITS;
  localparam int ERR_W  = RAD_W;
  localparam int MAG_W  = 52 - ANGLE_FRAC_BITS;
  localparam int SUM_W  = MAG_W + 1;
  localparam int MOD_STEPS = (MAG_W > 34) ? MAG_W - 33 : 1;
  localparam int CMP_W  = MAG_W + MOD_STEPS + 34;
  localparam int SB1_W  = IW + SW_ST + ERR_W;
  localparam int SBQ_W  = SB1_W + 33 + 1;
  localparam int SBE_W  = SB1_W + dqs_pkg::Q_W;
  localparam int E_W    = 59;
  localparam int B_W    = 63;
  localparam logic [IW-1:0] IDX_MASK = IW'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [60:0] RND = 61'd1 << (SH - 1);

  logic ce;
  logic skid_valid_r;
  assign ce        = !skid_valid_r;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  // configuration
  logic [dqs_pkg::ZS_W-1:0] zero_shift_r;
  logic [dqs_pkg::WL_W-1:0] wavelength_r;
  logic [39:0]              lam2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_shift_r <= '0;
      wavelength_r <= dqs_pkg::WAVELENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dqs_pkg::REG_ZERO_SHIFT: zero_shift_r <= cfg_data[dqs_pkg::ZS_W-1:0];
        dqs_pkg::REG_WAVELENGTH: wavelength_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lam2_r <= 40'(wavelength_r) * 40'(wavelength_r);
  end

  // stage 0: capture and sign split
  logic              s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  logic [IW-1:0]     s0_idx_r, s1_idx_r, s2_idx_r, s3_idx_r;
  logic [SW_ST-1:0]  s0_st_r, s1_st_r, s2_st_r, s3_st_r;
  logic [24:0]       s0_pmag_r, s0_wmag_r;
  logic              s0_pneg_r, s1_pneg_r, s2_pneg_r;
  logic [24:0]       in_pos, in_wid;
  logic [SW_ST-1:0]  in_st;

  assign in_pos = in_tdata[34:10];
  assign in_wid = in_tdata[59:35];

  always_comb begin
    if (wavelength_r == '0) begin
      in_st = dqs_pkg::ST_BAD_WAVE;
    end else if (in_wid[24]) begin
      in_st = dqs_pkg::ST_NEG_WIDTH;
    end else begin
      in_st = dqs_pkg::ST_OK;
    end
  end

  // stage 1: partial products, stage 2: rounded radians, stage 3: shifted sum
  logic [42:0]        s1_pl_r, s1_wl_r;
  logic [41:0]        s1_ph_r, s1_wh_r;
  logic [RAD_W-1:0]   s2_rad_r, s2_err_r, s3_err_r;
  logic [MAG_W-1:0]   s3_mag_r;
  logic               s3_neg_r;
  logic [60:0]        pos_full, wid_full;
  logic signed [SUM_W-1:0] rad_s, zs_s, sum_s;

  always_comb begin
    pos_full = 61'({s1_ph_r, 18'b0}) + 61'(s1_pl_r) + RND;
    wid_full = 61'({s1_wh_r, 18'b0}) + 61'(s1_wl_r) + RND;
    rad_s    = $signed(SUM_W'(s2_rad_r));
    zs_s     = SUM_W'($signed(zero_shift_r)) <<< (30 - ANGLE_FRAC_BITS);
    sum_s    = (s2_pneg_r ? -rad_s : rad_s) + zs_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (ce) begin
      s0_v_r <= in_tvalid & in_tuser;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_idx_r  <= in_tdata[IW-1:0] & IDX_MASK;
      s0_st_r   <= in_st;
      s0_pneg_r <= in_pos[24];
      s0_pmag_r <= in_pos[24] ? -in_pos : in_pos;
      s0_wmag_r <= in_wid[24] ? -in_wid : in_wid;

      s1_idx_r  <= s0_idx_r;
      s1_st_r   <= s0_st_r;
      s1_pneg_r <= s0_pneg_r;
      s1_pl_r   <= 43'(s0_pmag_r) * 43'(dqs_pkg::DEG_TO_RAD_Q40[17:0]);
      s1_ph_r   <= 42'(s0_pmag_r) * 42'(dqs_pkg::DEG_TO_RAD_Q40[34:18]);
      s1_wl_r   <= 43'(s0_wmag_r) * 43'(dqs_pkg::ERR_TO_RAD_Q40[17:0]);
      s1_wh_r   <= 42'(s0_wmag_r) * 42'(dqs_pkg::ERR_TO_RAD_Q40[34:18]);

      s2_idx_r  <= s1_idx_r;
      s2_st_r   <= s1_st_r;
      s2_pneg_r <= s1_pneg_r;
      s2_rad_r  <= RAD_W'(pos_full >> SH);
      s2_err_r  <= ERR_W'(wid_full >> SH);

      s3_idx_r  <= s2_idx_r;
      s3_st_r   <= s2_st_r;
      s3_err_r  <= s2_err_r;
      s3_neg_r  <= sum_s[SUM_W-1];
      s3_mag_r  <= MAG_W'(sum_s[SUM_W-1] ? -sum_s : sum_s);
    end
  end

  // reduction modulo two pi, one compare and subtract per cell
  logic              md_v_r   [MOD_STEPS];
  logic [IW-1:0]     md_idx_r [MOD_STEPS];
  logic [SW_ST-1:0]  md_st_r  [MOD_STEPS];
  logic [ERR_W-1:0]  md_err_r [MOD_STEPS];
  logic              md_neg_r [MOD_STEPS];
  logic [MAG_W-1:0]  md_mag_r [MOD_STEPS];

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    localparam logic [CMP_W-1:0] STEP_VAL =
      CMP_W'(dqs_pkg::TWO_PI_Q31) << (MOD_STEPS - 1 - j);
    logic             v_in, neg_in;
    logic [IW-1:0]    idx_in;
    logic [SW_ST-1:0] st_in;
    logic [ERR_W-1:0] err_in;
    logic [MAG_W-1:0] mag_in;
    if (j == 0) begin : g_first
      assign v_in = s3_v_r;
      assign neg_in = s3_neg_r;
      assign idx_in = s3_idx_r;
      assign st_in = s3_st_r;
      assign err_in = s3_err_r;
      assign mag_in = s3_mag_r;
    end else begin : g_next
      assign v_in = md_v_r[j-1];
      assign neg_in = md_neg_r[j-1];
      assign idx_in = md_idx_r[j-1];
      assign st_in = md_st_r[j-1];
      assign err_in = md_err_r[j-1];
      assign mag_in = md_mag_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_v_r[j] <= 1'b0;
      end else if (ce) begin
        md_v_r[j] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        md_idx_r[j] <= idx_in;
        md_st_r[j]  <= st_in;
        md_err_r[j] <= err_in;
        md_neg_r[j] <= neg_in;
        if (CMP_W'(mag_in) >= STEP_VAL) begin
          md_mag_r[j] <= MAG_W'(CMP_W'(mag_in) - STEP_VAL);
        end else begin
          md_mag_r[j] <= mag_in;
        end
      end
    end
  end

  // fold into the first quadrant
  logic                    rd_v_r;
  logic [SB1_W-1:0]        rd_sb_r;
  logic signed [dqs_pkg::Z_W-1:0] rd_z_r;
  logic signed [dqs_pkg::Z_W-1:0] r0, r1, r2, zf, pi_s, half_s, two_s;
  logic [SW_ST-1:0]        rd_st;

  always_comb begin
    pi_s   = $signed(dqs_pkg::Z_W'(dqs_pkg::PI_Q31));
    half_s = $signed(dqs_pkg::Z_W'(dqs_pkg::HALF_PI_Q31));
    two_s  = $signed(dqs_pkg::Z_W'(dqs_pkg::TWO_PI_Q31));
    r0 = $signed(dqs_pkg::Z_W'(34'(md_mag_r[MOD_STEPS-1])));
    if (md_neg_r[MOD_STEPS-1]) begin
      r0 = -r0;
    end
    r1 = (r0 < 0) ? r0 + two_s : r0;
    r2 = (r1 > pi_s) ? r1 - two_s : r1;
    zf = (r2 > half_s) ? pi_s - r2 : r2;
    rd_st = md_st_r[MOD_STEPS-1];
    if (rd_st == dqs_pkg::ST_OK && r2 < 0) begin
      rd_st = dqs_pkg::ST_SINE_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (ce) begin
      rd_v_r <= md_v_r[MOD_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rd_z_r  <= zf;
      rd_sb_r <= {md_idx_r[MOD_STEPS-1], rd_st, md_err_r[MOD_STEPS-1]};
    end
  end

  // cordic chain
  dqs_pkg::stage_ctl_t             cc_ctl [CORDIC_STAGES+1];
  logic signed [dqs_pkg::XY_W-1:0] cc_x   [CORDIC_STAGES+1];
  logic signed [dqs_pkg::XY_W-1:0] cc_y   [CORDIC_STAGES+1];
  logic signed [dqs_pkg::Z_W-1:0]  cc_z   [CORDIC_STAGES+1];
  logic [SB1_W-1:0]                cc_sb  [CORDIC_STAGES+1];

  assign cc_ctl[0].valid = rd_v_r;
  assign cc_x[0]  = $signed(dqs_pkg::XY_W'(dqs_pkg::GAIN_Q30));
  assign cc_y[0]  = '0;
  assign cc_z[0]  = rd_z_r;
  assign cc_sb[0] = rd_sb_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    dqs_cordic_cell #(
      .STAGE (i),
      .SB_W  (SB1_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .in_ctl  (cc_ctl[i]),
      .in_x    (cc_x[i]),
      .in_y    (cc_y[i]),
      .in_z    (cc_z[i]),
      .in_sb   (cc_sb[i]),
      .out_ctl (cc_ctl[i+1]),
      .out_x   (cc_x[i+1]),
      .out_y   (cc_y[i+1]),
      .out_z   (cc_z[i+1]),
      .out_sb  (cc_sb[i+1])
    );
  end

  // clamp, products, division setup
  logic              cl_v_r, m1_v_r, m2_v_r;
  logic [SB1_W-1:0]  cl_sb_r, m1_sb_r, m2_sb_r;
  logic [30:0]       cl_s_r, cl_c_r, s_cl, c_cl;
  logic [61:0]       m1_s2_r, m1_sc_r;
  logic [39:0]       m2_rem_r, m2_acc_r;
  logic [32:0]       m2_a_r;
  logic              m2_qsat_r;
  logic signed [dqs_pkg::XY_W-1:0] xo, yo, xa;
  logic [66:0]       nq;
  logic [61:0]       sc_rnd;

  always_comb begin
    xo = cc_x[CORDIC_STAGES];
    yo = cc_y[CORDIC_STAGES];
    xa = xo[dqs_pkg::XY_W-1] ? -xo : xo;
    if (yo[dqs_pkg::XY_W-1]) begin
      s_cl = '0;
    end else if (yo > $signed(dqs_pkg::XY_W'(dqs_pkg::ONE_Q30))) begin
      s_cl = dqs_pkg::ONE_Q30;
    end else begin
      s_cl = yo[30:0];
    end
    if (xa > $signed(dqs_pkg::XY_W'(dqs_pkg::ONE_Q30))) begin
      c_cl = dqs_pkg::ONE_Q30;
    end else begin
      c_cl = xa[30:0];
    end
    nq     = 67'({m1_s2_r, 6'b0}) + 67'(lam2_r >> 1);
    sc_rnd = (m1_sc_r + (62'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (ce) begin
      cl_v_r <= cc_ctl[CORDIC_STAGES].valid;
      m1_v_r <= cl_v_r;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cl_sb_r   <= cc_sb[CORDIC_STAGES];
      cl_s_r    <= s_cl;
      cl_c_r    <= c_cl;
      m1_sb_r   <= cl_sb_r;
      m1_s2_r   <= 62'(cl_s_r) * 62'(cl_s_r);
      m1_sc_r   <= 62'(cl_s_r) * 62'(cl_c_r);
      m2_sb_r   <= m1_sb_r;
      m2_rem_r  <= 40'(nq[66:40]);
      m2_acc_r  <= nq[39:0];
      m2_qsat_r <= 40'(nq[66:40]) >= lam2_r;
      m2_a_r    <= {sc_rnd[30:0], 2'b0};
    end
  end

  // q division chain
  dqs_pkg::stage_ctl_t qd_ctl [dqs_pkg::Q_W+1];
  logic [39:0]         qd_rem [dqs_pkg::Q_W+1];
  logic [39:0]         qd_acc [dqs_pkg::Q_W+1];
  logic [SBQ_W-1:0]    qd_sb  [dqs_pkg::Q_W+1];

  assign qd_ctl[0].valid = m2_v_r;
  assign qd_rem[0] = m2_rem_r;
  assign qd_acc[0] = m2_acc_r;
  assign qd_sb[0]  = {m2_sb_r, m2_a_r, m2_qsat_r};

  for (genvar i = 0; i < dqs_pkg::Q_W; i++) begin : g_qdiv
    dqs_div_cell #(.DIV_W(40), .ACC_W(40), .SB_W(SBQ_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .divisor (lam2_r),
      .in_ctl  (qd_ctl[i]),
      .in_rem  (qd_rem[i]),
      .in_acc  (qd_acc[i]),
      .in_sb   (qd_sb[i]),
      .out_ctl (qd_ctl[i+1]),
      .out_rem (qd_rem[i+1]),
      .out_acc (qd_acc[i+1]),
      .out_sb  (qd_sb[i+1])
    );
  end

  logic [SB1_W-1:0]        qd_meta;
  logic [32:0]             qd_a;
  logic                    qd_sat;
  logic [dqs_pkg::Q_W-1:0] qd_q;

  assign {qd_meta, qd_a, qd_sat} = qd_sb[dqs_pkg::Q_W];
  assign qd_q = qd_sat ? '1 : qd_acc[dqs_pkg::Q_W];

  // a * 2^26 / wavelength
  dqs_pkg::stage_ctl_t ed_ctl [E_W+1];
  logic [19:0]         ed_rem [E_W+1];
  logic [E_W-1:0]      ed_acc [E_W+1];
  logic [SBE_W-1:0]    ed_sb  [E_W+1];

  assign ed_ctl[0] = qd_ctl[dqs_pkg::Q_W];
  assign ed_rem[0] = '0;
  assign ed_acc[0] = {qd_a, 26'b0};
  assign ed_sb[0]  = {qd_meta, qd_q};

  for (genvar i = 0; i < E_W; i++) begin : g_ediv
    dqs_div_cell #(.DIV_W(20), .ACC_W(E_W), .SB_W(SBE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .divisor (wavelength_r),
      .in_ctl  (ed_ctl[i]),
      .in_rem  (ed_rem[i]),
      .in_acc  (ed_acc[i]),
      .in_sb   (ed_sb[i]),
      .out_ctl (ed_ctl[i+1]),
      .out_rem (ed_rem[i+1]),
      .out_acc (ed_acc[i+1]),
      .out_sb  (ed_sb[i+1])
    );
  end

  // e * 16 / wavelength
  dqs_pkg::stage_ctl_t bd_ctl [B_W+1];
  logic [19:0]         bd_rem [B_W+1];
  logic [B_W-1:0]      bd_acc [B_W+1];
  logic [SBE_W-1:0]    bd_sb  [B_W+1];

  assign bd_ctl[0] = ed_ctl[E_W];
  assign bd_rem[0] = '0;
  assign bd_acc[0] = {ed_acc[E_W], 4'b0};
  assign bd_sb[0]  = ed_sb[E_W];

  for (genvar i = 0; i < B_W; i++) begin : g_bdiv
    dqs_div_cell #(.DIV_W(20), .ACC_W(B_W), .SB_W(SBE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .divisor (wavelength_r),
      .in_ctl  (bd_ctl[i]),
      .in_rem  (bd_rem[i]),
      .in_acc  (bd_acc[i]),
      .in_sb   (bd_sb[i]),
      .out_ctl (bd_ctl[i+1]),
      .out_rem (bd_rem[i+1]),
      .out_acc (bd_acc[i+1]),
      .out_sb  (bd_sb[i+1])
    );
  end

  // variance: partial products, rounding, square
  logic [IW-1:0]           bd_idx;
  logic [SW_ST-1:0]        bd_st;
  logic [ERR_W-1:0]        bd_err;
  logic [dqs_pkg::Q_W-1:0] bd_q;
  logic [63:0]             b_pad, e_pad;

  assign {bd_idx, bd_st, bd_err, bd_q} = bd_sb[B_W];
  assign b_pad = 64'(bd_acc[B_W]);
  assign e_pad = 64'(bd_err);

  logic                    p1_v_r, p2_v_r, p3_v_r;
  logic [IW-1:0]           p1_idx_r, p2_idx_r, p3_idx_r;
  logic [SW_ST-1:0]        p1_st_r, p2_st_r, p3_st_r;
  logic [dqs_pkg::Q_W-1:0] p1_q_r, p2_q_r, p3_q_r;
  logic [63:0]             p1_m00_r, p1_m01_r, p1_m10_r, p1_m11_r;
  logic [31:0]             p2_g_r;
  logic                    p2_sat_r, p3_sat_r;
  logic [63:0]             p3_g2_r;
  logic [127:0]            prod;
  logic [97:0]             g_full;

  always_comb begin
    prod = (128'(p1_m11_r) << 64) + (128'(p1_m01_r) << 32) + (128'(p1_m10_r) << 32)
         + 128'(p1_m00_r);
    g_full = 98'((prod + (128'd1 << 29)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (ce) begin
      p1_v_r <= bd_ctl[B_W].valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_idx_r <= bd_idx;
      p1_st_r  <= bd_st;
      p1_q_r   <= bd_q;
      p1_m00_r <= 64'(b_pad[31:0]) * 64'(e_pad[31:0]);
      p1_m01_r <= 64'(b_pad[31:0]) * 64'(e_pad[63:32]);
      p1_m10_r <= 64'(b_pad[63:32]) * 64'(e_pad[31:0]);
      p1_m11_r <= 64'(b_pad[63:32]) * 64'(e_pad[63:32]);
      p2_idx_r <= p1_idx_r;
      p2_st_r  <= p1_st_r;
      p2_q_r   <= p1_q_r;
      p2_g_r   <= g_full[31:0];
      p2_sat_r <= |g_full[97:32];
      p3_idx_r <= p2_idx_r;
      p3_st_r  <= p2_st_r;
      p3_q_r   <= p2_q_r;
      p3_sat_r <= p2_sat_r;
      p3_g2_r  <= 64'(p2_g_r) * 64'(p2_g_r);
    end
  end

  // final result and output register with skid
  logic [56:0]               var_full;
  logic [dqs_pkg::VAR_W-1:0] var_sat;
  logic [dqs_pkg::Q_W-1:0]   push_q;
  logic [dqs_pkg::VAR_W-1:0] push_var;
  logic                      push;

  always_comb begin
    var_full = 57'((65'(p3_g2_r) + 65'd128) >> 8);
    var_sat  = (p3_sat_r | var_full[56]) ? '1 : var_full[55:0];
    if (p3_st_r == dqs_pkg::ST_OK) begin
      push_q   = p3_q_r;
      push_var = var_sat;
    end else begin
      push_q   = '0;
      push_var = '0;
    end
    push = p3_v_r & ce;
  end

  logic                      out_valid_r;
  logic [IW-1:0]             out_idx_r, sk_idx_r;
  logic [dqs_pkg::Q_W-1:0]   out_q_r, sk_q_r;
  logic [dqs_pkg::VAR_W-1:0] out_var_r, sk_var_r;
  logic [SW_ST-1:0]          out_st_r, sk_st_r;
  logic                      out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_idx_r <= sk_idx_r;
        out_q_r   <= sk_q_r;
        out_var_r <= sk_var_r;
        out_st_r  <= sk_st_r;
      end else begin
        out_idx_r <= p3_idx_r;
        out_q_r   <= push_q;
        out_var_r <= push_var;
        out_st_r  <= p3_st_r;
      end
    end else if (push) begin
      sk_idx_r <= p3_idx_r;
      sk_q_r   <= push_q;
      sk_var_r <= push_var;
      sk_st_r  <= p3_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_var_r, out_q_r, out_idx_r};
  assign out_tuser  = out_st_r;

endmodule

>>> tb/tb.sv
// testbench for diffraction_angle_to_q_core: directed and random peaks checked against a predictor
module tb;

  typedef struct {
    logic [dqs_pkg::IDX_W-1:0] idx;
    logic [dqs_pkg::Q_W-1:0]   q;
    logic [dqs_pkg::VAR_W-1:0] q_var;
    logic [dqs_pkg::ST_W-1:0]  st;
  } peak_result_t;

  logic clk;
  logic rst_n;
  logic [63:0] in_tdata;
  logic in_tuser, in_tvalid, in_tready;
  logic [111:0] out_tdata;
  logic [dqs_pkg::ST_W-1:0] out_tuser;
  logic out_tvalid, out_tready;
  logic cfg_valid, cfg_ready;
  logic [dqs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dqs_pkg::CFG_DATA_W-1:0] cfg_data;

  logic signed [dqs_pkg::ZS_W-1:0] zero_shift_reg;
  logic [dqs_pkg::WL_W-1:0] wavelength_reg;
  peak_result_t pending_results[$];
  int errors, peaks_sent, results_seen, burst_left, stall_left, idle_cycles;
  int cfg_writes;

  diffraction_angle_to_q_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint rad_q30(longint v, longint unsigned k);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag * k + (64'd1 << 25)) >> 26;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void predict_peak(input logic [dqs_pkg::IDX_W-1:0] idx,
                                       input logic signed [dqs_pkg::ANGLE_W-1:0] pos,
                                       input logic signed [dqs_pkg::ANGLE_W-1:0] wid,
                                       output peak_result_t res);
    longint ang, zs, x, y, z, dx, dy;
    longint unsigned s, c, lam, lam2, num, q1, rem, sc, a, e, b, err, g;
    res.idx = idx;
    res.q = '0;
    res.q_var = '0;
    res.st = dqs_pkg::ST_OK;
    if (wavelength_reg == '0) begin
      res.st = dqs_pkg::ST_BAD_WAVE;
    end else if (wid < 0) begin
      res.st = dqs_pkg::ST_NEG_WIDTH;
    end else begin
      zs = longint'(zero_shift_reg) * 16384;
      ang = (rad_q30(longint'(pos), longint'(dqs_pkg::DEG_TO_RAD_Q40)) + zs)
            % longint'(dqs_pkg::TWO_PI_Q31);
      if (ang < 0) ang += longint'(dqs_pkg::TWO_PI_Q31);
      if (ang > longint'(dqs_pkg::PI_Q31)) ang -= longint'(dqs_pkg::TWO_PI_Q31);
      if (ang < 0) begin
        res.st = dqs_pkg::ST_SINE_RANGE;
      end else begin
        if (ang > longint'(dqs_pkg::HALF_PI_Q31)) ang = longint'(dqs_pkg::PI_Q31) - ang;
        x = longint'(dqs_pkg::GAIN_Q30);
        y = 0;
        z = ang;
        for (int i = 0; i < dqs_pkg::CORDIC_STAGES_DEF; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= 2 * longint'(dqs_pkg::ATAN_Q30[i]);
          end else begin
            x += dx; y -= dy; z += 2 * longint'(dqs_pkg::ATAN_Q30[i]);
          end
        end
        if (y < 0) y = 0;
        if (y > longint'(dqs_pkg::ONE_Q30)) y = longint'(dqs_pkg::ONE_Q30);
        if (x < 0) x = -x;
        if (x > longint'(dqs_pkg::ONE_Q30)) x = longint'(dqs_pkg::ONE_Q30);
        s = y;
        c = x;
        lam = 64'(wavelength_reg);
        lam2 = lam * lam;
        num = 4 * s * s;
        q1 = num / lam2;
        rem = num % lam2;
        if (q1 >= (64'd1 << 36)) begin
          res.q = '1;
        end else begin
          num = (q1 << 4) + ((rem << 4) + (lam2 >> 1)) / lam2;
          res.q = (num > 64'hFF_FFFF_FFFF) ? '1 : num[dqs_pkg::Q_W-1:0];
        end
        err = rad_q30(longint'(wid), longint'(dqs_pkg::ERR_TO_RAD_Q40));
        sc = (s * c + (64'd1 << 29)) >> 30;
        a = 4 * sc;
        e = ((a / lam) << 26) + ((a % lam) << 26) / lam;
        b = ((e / lam) << 4) + ((e % lam) << 4) / lam;
        if (err != 0 && b > ((64'd1 << 62) - 1) / err) begin
          res.q_var = '1;
        end else begin
          g = (b * err + (64'd1 << 29)) >> 30;
          if (g > 64'hFFFF_FFFF) res.q_var = '1;
          else begin
            g = (g * g + 128) >> 8;
            res.q_var = (g > 64'hFF_FFFF_FFFF_FFFF) ? '1 : g[dqs_pkg::VAR_W-1:0];
          end
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
  endtask

  // result checker
  always @(posedge clk) begin
    peak_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[63:0], 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[9:0] !== want.idx)
          report_mismatch("index", 64'(out_tdata[9:0]), 64'(want.idx));
        if (out_tdata[49:10] !== want.q)
          report_mismatch("q", 64'(out_tdata[49:10]), 64'(want.q));
        if (out_tdata[105:50] !== want.q_var)
          report_mismatch("variance", 64'(out_tdata[105:50]), 64'(want.q_var));
        if (out_tuser !== want.st)
          report_mismatch("status", 64'(out_tuser), 64'(want.st));
      end
    end
  end

  // receiver stalls, with calm stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (($urandom_range(0, 1023) >= 256) && ($urandom_range(0, 5) == 0))
        stall_left = $urandom_range(1, 10);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_peak(input logic [dqs_pkg::IDX_W-1:0] idx, input bit use_it,
                           input logic signed [dqs_pkg::ANGLE_W-1:0] pos,
                           input logic signed [dqs_pkg::ANGLE_W-1:0] wid);
    peak_result_t res;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
    end
    in_tdata <= {4'b0, wid, pos, idx};
    in_tuser <= use_it;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    peaks_sent++;
    if (use_it) begin
      predict_peak(idx, pos, wid, res);
      pending_results = {pending_results, res};
    end
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dqs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dqs_pkg::CFG_DATA_W-1:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dqs_pkg::REG_ZERO_SHIFT) zero_shift_reg = val[dqs_pkg::ZS_W-1:0];
    else if (idx == dqs_pkg::REG_WAVELENGTH) wavelength_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    logic signed [dqs_pkg::ANGLE_W-1:0] pos, wid;
    bit use_it;
    for (int i = 0; i < count; i++) begin
      use_it = ($urandom_range(0, 9) != 0);
      pos = 25'($urandom_range(0, 23592960) - 11796480);
      if ($urandom_range(0, 3) == 0) pos = 25'($urandom_range(0, 11796480));
      wid = $urandom_range(0, 7) == 0 ? 25'(-$urandom_range(1, 11796480))
                                      : 25'($urandom_range(0, 11796480));
      if ($urandom_range(0, 2) == 0) wid = 25'($urandom_range(0, 65536));
      send_peak(10'($urandom_range(0, 1023)), use_it, pos, wid);
      if (i == count / 2 && $urandom_range(0, 1)) drain_results();
    end
  endtask

  task automatic test_directed();
    send_peak(10'd0, 1'b1, 25'sd0, 25'sd0);
    send_peak(10'd1023, 1'b1, 25'sd11796480, 25'sd11796480);
    send_peak(10'd2, 1'b1, -25'sd11796480, 25'sd0);
    send_peak(10'd3, 1'b1, 25'sd5898240, 25'sd65536);
    send_peak(10'd4, 1'b1, 25'sd2949120, 25'sd6553);
    send_peak(10'd5, 1'b1, -25'sd65536, 25'sd100);
    send_peak(10'd6, 1'b1, 25'sd1966080, -25'sd1);
    send_peak(10'd7, 1'b1, 25'sd1966080, -25'sd11796480);
    send_peak(10'd8, 1'b0, 25'sd1966080, 25'sd1000);
    send_peak(10'd9, 1'b1, 25'sd11796479, 25'sd1);
    send_peak(10'd10, 1'b1, 25'sd8847360, 25'sd1);
    send_peak(10'd11, 1'b0, -25'sd1, -25'sd1);
    send_peak(10'd12, 1'b1, 25'sd1, 25'sd11796480);
  endtask

  task automatic test_random();
    send_random(300);
  endtask

  task automatic test_bad_wavelength();
    write_reg(dqs_pkg::REG_WAVELENGTH, 20'd0);
    send_peak(10'd20, 1'b1, 25'sd1966080, 25'sd1000);
    send_peak(10'd21, 1'b1, 25'sd1966080, -25'sd5);
    send_peak(10'd22, 1'b0, 25'sd1966080, 25'sd5);
    send_random(60);
  endtask

  task automatic test_register_sweep();
    write_reg(dqs_pkg::REG_WAVELENGTH, 20'd1);
    write_reg(dqs_pkg::REG_ZERO_SHIFT, 20'(-205887));
    send_random(250);
    write_reg(dqs_pkg::REG_WAVELENGTH, 20'd1048575);
    write_reg(dqs_pkg::REG_ZERO_SHIFT, 20'd205887);
    send_random(250);
    write_reg(dqs_pkg::REG_WAVELENGTH, dqs_pkg::WAVELENGTH_RESET);
    write_reg(dqs_pkg::REG_ZERO_SHIFT, 20'd0);
    send_random(250);
    for (int k = 0; k < 3; k++) begin
      write_reg(dqs_pkg::REG_WAVELENGTH, 20'($urandom_range(1, 1048575)));
      write_reg(dqs_pkg::REG_ZERO_SHIFT, 20'($urandom_range(0, 411774) - 205887));
      send_random(200);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tdata = '0; in_tuser = 1'b0; in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    zero_shift_reg = '0;
    wavelength_reg = dqs_pkg::WAVELENGTH_RESET;
    errors = 0; peaks_sent = 0; results_seen = 0; burst_left = 0;
    stall_left = 0; idle_cycles = 0; cfg_writes = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_bad_wavelength();
    test_register_sweep();
    drain_results();
    $display("covered %0d peaks, %0d results checked, %0d register writes", peaks_sent,
             results_seen, cfg_writes);
    $display("wavelength from zero to full scale, zero shift at both limits, random stalls");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/dqs_pkg.sv
hdl/dqs_cordic_cell.sv
hdl/dqs_div_cell.sv
hdl/diffraction_angle_to_q_core.sv
tb/tb.sv
